// File: hdl/sqe_pkg.sv
// Shared types and codes for the stack/queue engine.
package sqe_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LIST = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SWAP = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FEW   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

// File: hdl/sqe_mem.sv
// Element memory: one write port, one read port with registered read data.
module sqe_mem #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                     clock,
   input  sqe_pkg::mem_cmd_type     cmd,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [sqe_pkg::DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic [sqe_pkg::DATA_W-1:0] rd_data
);
   import sqe_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sqe_ctrl.sv
// Sequencer: ring pointers, operation decode, memory commands and result register.
module sqe_ctrl #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sqe_pkg::DATA_W-1:0]  req_tdata,
   input  logic [sqe_pkg::FUNC_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sqe_pkg::DATA_W-1:0]  rsp_tdata,
   output logic [sqe_pkg::STATUS_W:0]  rsp_tuser,
   output logic                        rsp_tlast,
   input  logic                        csr_wen,
   input  logic                        csr_wdata,
   output sqe_pkg::mem_cmd_type        mem_cmd,
   output logic [IDX_W-1:0]            mem_wr_addr,
   output logic [sqe_pkg::DATA_W-1:0]  mem_wr_data,
   output logic [IDX_W-1:0]            mem_rd_addr,
   input  logic [sqe_pkg::DATA_W-1:0]  mem_rd_data
);
   import sqe_pkg::*;

   localparam int SUM_W = IDX_W + 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXEC  = 7'b0000010,
      S_PEEK  = 7'b0000100,
      S_SWAPA = 7'b0001000,
      S_SWAPB = 7'b0010000,
      S_SWAPC = 7'b0100000,
      S_LIST  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    rp_ff, rp_in;
   logic [DATA_W-1:0]   tmp_ff, tmp_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic                queue_mode_ff;

   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_data_ff, out_data_in;
   logic                out_has_ff, out_has_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   logic                out_free;
   logic                emit;
   logic [DATA_W-1:0]   e_data;
   logic                e_has;
   logic [STATUS_W-1:0] e_status;
   logic                e_last;

   logic                empty, full;
   logic [IDX_W-1:0]    front_inc, front_dec, rp_inc, back_addr;
   logic [SUM_W-1:0]    back_sum;

   assign out_free = !out_valid_ff || rsp_tready;
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));

   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + IDX_W'(1);
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign rp_inc    = (rp_ff == IDX_W'(DEPTH - 1)) ? '0 : rp_ff + IDX_W'(1);
   // front + count is below twice the depth, so one subtract wraps it
   assign back_sum  = {1'b0, front_ff} + SUM_W'(count_ff);
   assign back_addr = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(back_sum);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      rp_in       = rp_ff;
      tmp_in      = tmp_ff;
      func_in     = func_ff;
      val_in      = val_ff;
      mem_cmd     = '0;
      mem_wr_addr = front_ff;
      mem_wr_data = val_ff;
      mem_rd_addr = front_ff;
      emit        = 1'b0;
      e_data      = '0;
      e_has       = 1'b0;
      e_status    = ST_OK;
      e_last      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               val_in   = req_tdata;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (func_ff)
               FUNC_PUSH: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (full) begin
                        e_status = ST_FULL;
                     end else begin
                        mem_cmd.wr_en = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        if (queue_mode_ff) begin
                           mem_wr_addr = back_addr;
                        end else begin
                           mem_wr_addr = front_dec;
                           front_in    = front_dec;
                        end
                     end
                  end
               end
               FUNC_LIST: begin
                  if (empty) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_status = ST_EMPTY;
                        state_in = S_IDLE;
                     end
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     rp_in         = front_inc;
                     idx_in        = '0;
                     state_in      = S_LIST;
                  end
               end
               FUNC_PEEK: begin
                  if (empty) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_status = ST_EMPTY;
                        state_in = S_IDLE;
                     end
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     state_in      = S_PEEK;
                  end
               end
               FUNC_POP: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (empty) begin
                        e_status = ST_EMPTY;
                     end else begin
                        front_in = front_inc;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               FUNC_SWAP: begin
                  if (count_ff < CNT_W'(2)) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_status = ST_FEW;
                        state_in = S_IDLE;
                     end
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     state_in      = S_SWAPA;
                  end
               end
               default: begin
                  // unused codes: no result, no change
                  state_in = S_IDLE;
               end
            endcase
         end
         S_PEEK: begin
            if (out_free) begin
               emit     = 1'b1;
               e_data   = mem_rd_data;
               e_has    = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SWAPA: begin
            tmp_in        = mem_rd_data;
            mem_cmd.rd_en = 1'b1;
            mem_rd_addr   = front_inc;
            state_in      = S_SWAPB;
         end
         S_SWAPB: begin
            mem_cmd.wr_en = 1'b1;
            mem_wr_data   = mem_rd_data;
            state_in      = S_SWAPC;
         end
         S_SWAPC: begin
            if (out_free) begin
               mem_cmd.wr_en = 1'b1;
               mem_wr_addr   = front_inc;
               mem_wr_data   = tmp_ff;
               emit          = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LIST: begin
            // read data holds while the result register is blocked
            if (out_free) begin
               emit   = 1'b1;
               e_data = mem_rd_data;
               e_has  = 1'b1;
               e_last = (idx_ff == count_ff - CNT_W'(1));
               if (e_last) begin
                  state_in = S_IDLE;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  mem_rd_addr   = rp_ff;
                  rp_in         = rp_inc;
                  idx_in        = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      out_has_in    = out_has_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_data_in   = e_data;
         out_has_in    = e_has;
         out_status_in = e_status;
         out_last_in   = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         queue_mode_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_wen) begin
            queue_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rp_ff         <= rp_in;
      tmp_ff        <= tmp_in;
      func_ff       <= func_in;
      val_ff        <= val_in;
      out_data_ff   <= out_data_in;
      out_has_ff    <= out_has_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_status_ff, out_has_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// File: hdl/stack_queue_engine.sv
// Top level of the bounded stack/queue engine.
// Bounded store of up to DEPTH signed 32-bit values in a ring held in a single-port-read,
// single-port-write memory; csr_wdata selects stack (0, push at front) or queue (1, push
// at back); the user must write it only while the engine is idle, not enforced by the block.
// One request is handled at a time; the result register lets the next request in while a
// result waits. Peek reads the front element before replying; swap makes two reads and two
// writes through the one read and one write port; a list returns one result per stored
// element, read in turn. rsp_tuser flags results that carry data and the status code.
module stack_queue_engine #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sqe_pkg::DATA_W-1:0]  req_tdata,   // [31:0] push_value
   input  logic [sqe_pkg::FUNC_W-1:0]  req_tuser,   // [2:0] func
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sqe_pkg::DATA_W-1:0]  rsp_tdata,   // [31:0] data_value
   output logic [sqe_pkg::STATUS_W:0]  rsp_tuser,   // [0] has_data, [2:1] status
   output logic                        rsp_tlast,
   input  logic                        csr_wen,
   input  logic                        csr_wdata    // queue_mode
);
   import sqe_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mem_cmd_type        mem_cmd;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [DATA_W-1:0]  mem_wr_data;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [DATA_W-1:0]  mem_rd_data;

   sqe_mem #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sqe_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .mem_cmd     (mem_cmd),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // one request in flight: the port closes right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request port open right after a transfer");

   // reads and writes are never issued in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("memory read and write in the same cycle");

   // a result with data always reports ok
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == ST_OK)
      else $error("data result with error status");

   // an error result is always the only result of its request
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] != ST_OK |-> rsp_tlast && !rsp_tuser[0])
      else $error("error result not final or carries data");

endmodule

// File: verif/tb.sv
// Self-checking bench for stack_queue_engine: directed and random requests, inline model.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sqe_pkg::*;

   localparam int DEPTH = 64;
   localparam logic [FUNC_W-1:0] FUNC_TOP = 3'd7;   // highest code the func field can carry
   localparam int SETTLE_CYCLES = 80;               // longer than a list of a full store
   localparam int STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] value;
   } request_type;

   typedef struct packed {
      logic [DATA_W-1:0]   value;
      logic                has_data;
      logic [STATUS_W-1:0] status;
      logic                last;
   } result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;
   logic [FUNC_W-1:0]   req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W:0]   rsp_tuser;
   logic                rsp_tlast;
   logic                csr_wen    = 1'b0;
   logic                csr_wdata  = 1'b0;

   stack_queue_engine #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the ring, advanced on each accepted request.
   logic [DATA_W-1:0] ring_mem [DEPTH];
   int                front_pos  = 0;
   int                live_count = 0;
   logic              queue_mode = 1'b0;

   request_type req_backlog [$];
   result_type  owed_results [$];
   request_type drv_item;

   int plan_count    = 0;   // occupancy as the stimulus is planned
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors        = 0;
   int n_requests    = 0;
   int n_results     = 0;
   int n_data        = 0;
   int n_full        = 0;
   int stall_cycles  = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void owe(logic [DATA_W-1:0] value, logic has, logic [STATUS_W-1:0] status,
                               logic last);
      result_type r;
      r = '{value: value, has_data: has, status: status, last: last};
      owed_results.push_back(r);
   endfunction

   function automatic void run_request(request_type rq);
      logic [DATA_W-1:0] tmp;
      int                nxt;
      case (rq.func)
         FUNC_PUSH: begin
            if (live_count >= DEPTH) begin
               owe('0, 1'b0, ST_FULL, 1'b1);
            end else begin
               if (queue_mode) begin
                  ring_mem[(front_pos + live_count) % DEPTH] = rq.value;
               end else begin
                  front_pos = (front_pos + DEPTH - 1) % DEPTH;
                  ring_mem[front_pos] = rq.value;
               end
               live_count++;
               owe('0, 1'b0, ST_OK, 1'b1);
            end
         end
         FUNC_LIST: begin
            if (live_count == 0) begin
               owe('0, 1'b0, ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < live_count; i++)
                  owe(ring_mem[(front_pos + i) % DEPTH], 1'b1, ST_OK, i == live_count - 1);
            end
         end
         FUNC_PEEK: begin
            if (live_count == 0) owe('0, 1'b0, ST_EMPTY, 1'b1);
            else owe(ring_mem[front_pos], 1'b1, ST_OK, 1'b1);
         end
         FUNC_POP: begin
            if (live_count == 0) begin
               owe('0, 1'b0, ST_EMPTY, 1'b1);
            end else begin
               front_pos = (front_pos + 1) % DEPTH;
               live_count--;
               owe('0, 1'b0, ST_OK, 1'b1);
            end
         end
         FUNC_SWAP: begin
            if (live_count < 2) begin
               owe('0, 1'b0, ST_FEW, 1'b1);
            end else begin
               nxt = (front_pos + 1) % DEPTH;
               tmp = ring_mem[front_pos];
               ring_mem[front_pos] = ring_mem[nxt];
               ring_mem[nxt] = tmp;
               owe('0, 1'b0, ST_OK, 1'b1);
            end
         end
         default: ;   // unused codes: no result, no state change
      endcase
   endfunction

   function automatic void plan(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value);
      request_type rq;
      rq = '{func: func, value: value};
      req_backlog.push_back(rq);
      if (func == FUNC_PUSH && plan_count < DEPTH) plan_count++;
      if (func == FUNC_POP && plan_count > 0) plan_count--;
   endfunction

   function automatic logic [DATA_W-1:0] rand_word();
      logic [DATA_W-1:0] w;
      w = $urandom;
      case ($urandom_range(5))
         0: w = 32'h8000_0000;
         1: w = 32'h7fff_ffff;
         2: w = 32'($urandom_range(40)) - 32'd20;
         default: ;
      endcase
      return w;
   endfunction

   function automatic void plan_noise();
      plan(FUNC_W'($urandom_range(FUNC_TOP, FUNC_SWAP + 1)), $urandom);
   endfunction

   // Random mix; ignored codes are sprinkled in but not counted.
   function automatic void plan_mix(int n);
      int done;
      int r;
      done = 0;
      while (done < n) begin
         r = $urandom_range(99);
         if (r >= 92) begin
            plan_noise();
         end else begin
            if (r < 40) plan(FUNC_PUSH, rand_word());
            else if (r < 58) plan(FUNC_POP, $urandom);
            else if (r < 68) plan(FUNC_PEEK, $urandom);
            else if (r < 80) plan(FUNC_SWAP, $urandom);
            else plan(FUNC_LIST, $urandom);
            done++;
         end
      end
   endfunction

   function automatic void plan_fill(int extra);
      while (plan_count < DEPTH) plan(FUNC_PUSH, rand_word());
      repeat (extra) plan(FUNC_PUSH, rand_word());
   endfunction

   function automatic void plan_drain(int extra);
      while (plan_count > 0) plan(FUNC_POP, $urandom);
      repeat (extra) plan(FUNC_POP, $urandom);
   endfunction

   task automatic write_mode(logic mode);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_wen   <= 1'b0;
      queue_mode = mode;
   endtask

   // Unused codes give no result, so allow the engine to finish after the last one.
   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_tvalid || owed_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void check_result();
      result_type want;
      if (owed_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected result: expected none, got data %h user %b last %b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         want = owed_results.pop_front();
         n_results++;
         if (want.has_data) n_data++;
         if (want.status == ST_FULL) n_full++;
         if (rsp_tdata !== want.value) begin
            errors++;
            $display("%0t: data_value mismatch: expected %h, got %h", $time, want.value,
                     rsp_tdata);
         end
         if (rsp_tuser[0] !== want.has_data) begin
            errors++;
            $display("%0t: has_data mismatch: expected %b, got %b", $time, want.has_data,
                     rsp_tuser[0]);
         end
         if (rsp_tuser[STATUS_W:1] !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status,
                     rsp_tuser[STATUS_W:1]);
         end
         if (rsp_tlast !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, got %b", $time, want.last, rsp_tlast);
         end
      end
   endfunction

   // Request driver: one nonblocking update of tvalid per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            run_request('{func: req_tuser, value: req_tdata});
            n_requests++;
         end
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_item = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= drv_item.func;
            req_tdata  <= drv_item.value;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor with random backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: only counts while work is outstanding and no transfer happens.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (req_backlog.size() == 0 && !req_tvalid && owed_results.size() == 0))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results still owed", $time, owed_results.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Stack mode, sender idles less than receiver.
      send_idle_pct = 33;
      recv_idle_pct = 67;
      write_mode(1'b0);
      plan(FUNC_LIST, 32'h0);
      plan(FUNC_PEEK, 32'h0);
      plan(FUNC_POP, 32'hffff_ffff);
      plan(FUNC_SWAP, 32'h0);
      plan(FUNC_SWAP + 3'd1, 32'h1234_5678);
      plan(FUNC_TOP - 3'd1, 32'hffff_ffff);
      plan(FUNC_TOP, 32'h0);
      plan(FUNC_PUSH, 32'h7fff_ffff);
      plan(FUNC_SWAP, 32'h0);            // only one element
      plan(FUNC_PEEK, 32'h0);
      plan(FUNC_PUSH, 32'h8000_0000);
      plan(FUNC_PUSH, 32'h0);
      plan(FUNC_PUSH, 32'hffff_ffff);
      plan(FUNC_LIST, 32'h0);
      plan(FUNC_SWAP, 32'h0);
      plan(FUNC_PEEK, 32'h0);
      plan(FUNC_POP, 32'h0);
      plan(FUNC_LIST, 32'h0);
      plan(FUNC_POP, 32'h0);
      plan(FUNC_POP, 32'h0);
      plan(FUNC_POP, 32'h0);
      plan(FUNC_POP, 32'h0);             // empty again
      plan_mix(35);
      wait_idle();

      // Queue mode, receiver idles less than sender; run into the full store.
      send_idle_pct = 67;
      recv_idle_pct = 33;
      write_mode(1'b1);
      plan_fill(2);
      plan(FUNC_LIST, 32'h0);
      plan(FUNC_PEEK, 32'h0);
      plan(FUNC_SWAP, 32'h0);
      plan_mix(25);
      wait_idle();

      // Back to stack mode, no idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_mode(1'b0);
      plan_mix(10);
      plan_fill(1);
      plan(FUNC_LIST, 32'h0);
      plan_drain(2);
      plan(FUNC_LIST, 32'h0);
      plan_mix(25);
      wait_idle();

      $display("Covered %0d requests in stack and queue modes, including full and empty store.",
               n_requests);
      $display("Checked %0d results: %0d with data, %0d store-full.", n_results, n_data, n_full);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
